// File: rtl/idq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants of the indexed deque: word layouts, operation
// and status codes, configuration register indexes and storage sizes.
// ----------------------------------------------------------------------------
package idq_pkg;

	// ring storage size (power of two, the ring pointer wraps by truncation)
	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int DATA_W = 32;

	// operation codes
	localparam logic [2:0] OP_FETCH     = 3'd0;
	localparam logic [2:0] OP_STORE     = 3'd1;
	localparam logic [2:0] OP_PUSH_HIGH = 3'd2;
	localparam logic [2:0] OP_PUSH_LOW  = 3'd3;
	localparam logic [2:0] OP_POP_HIGH  = 3'd4;
	localparam logic [2:0] OP_POP_LOW   = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_LAST  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE  = 2'd2;

	// input word
	typedef struct packed {
		logic [2:0]               operation;
		logic signed [DATA_W-1:0] index;
		logic signed [DATA_W-1:0] value;
	} idq_in_t;

	// result word
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] low_index;
		logic signed [DATA_W-1:0] high_index;
		logic [CNT_W-1:0]         element_count;
		logic [1:0]               status;
	} idq_out_t;

endpackage

// File: rtl/idq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/indexed_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_core
// Integer array with movable bounds kept as a ring buffer plus a logical
// low bound, with fetch/store by logical index and push/pop at either end.
// ----------------------------------------------------------------------------
// A word is taken on every clock edge where start is high (busy stays low),
// one word per cycle with no gaps needed. Its result appears on result with
// done high for exactly one cycle, in order; the receiver cannot stall, so
// results must be captured when done is high. The stages are the input
// register, the registered read of the element RAM (one read and one write
// port, one access each per word) and the result register. A configuration
// write rebuilds the array at once; issue it only while no result is
// outstanding.
module indexed_deque_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  idq_pkg::idq_in_t                      request,
	output logic                                  done,
	output idq_pkg::idq_out_t                     result,
	input  logic                                  cfg_we,
	input  logic [idq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [idq_pkg::DATA_W-1:0]            cfg_data
);

	localparam int PW = idq_pkg::PTR_W;
	localparam int CW = idq_pkg::CNT_W;
	localparam int DW = idq_pkg::DATA_W;

	// configuration registers
	logic signed [DW-1:0] cfg_low_q;
	logic [CW-1:0]        cfg_count_q;
	logic [DW-1:0]        cfg_fill_q;

	// deque state
	logic [PW-1:0]                 ring_q;
	logic [CW-1:0]                 count_q;
	logic signed [DW-1:0]          low_q;
	logic [idq_pkg::DEPTH-1:0]     mark_q;

	// pipeline
	logic              v_s1;
	idq_pkg::idq_in_t  in_s1;
	logic              v_s2;
	logic              rd_s2;
	logic              mark_s2;
	logic signed [DW-1:0] low_s2;
	logic signed [DW-1:0] high_s2;
	logic [CW-1:0]     count_s2;
	logic [1:0]        status_s2;

	logic [DW-1:0]     ram_rdata;

	// stage 1 decode results
	logic              accept;
	logic              rebuild;
	logic signed [DW-1:0] nb_low;
	logic [CW-1:0]     nb_count_raw;
	logic [CW-1:0]     nb_count;
	logic [DW:0]       nb_room;
	logic signed [DW-1:0] op_idx;
	logic signed [DW-1:0] high_cur;
	logic [DW-1:0]     off_idx;
	logic [CW-1:0]     last_off;
	logic              in_range;
	logic              is_full;
	logic              wr_en;
	logic              rd_en;
	logic [PW-1:0]     wr_slot;
	logic [PW-1:0]     rd_slot;
	logic [PW-1:0]     nxt_ring;
	logic signed [DW-1:0] nxt_low;
	logic [CW-1:0]     nxt_count;
	logic signed [DW-1:0] nxt_high;
	logic [1:0]        op_status;

	// one word per cycle, never held off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// a write beyond the register list is ignored
	assign rebuild = cfg_we && (cfg_index == idq_pkg::CFG_START_LOW
		|| cfg_index == idq_pkg::CFG_START_COUNT || cfg_index == idq_pkg::CFG_FILL_VALUE);

	// rebuild values, with the count clamped to 1..DEPTH and to the bound room
	always_comb begin
		nb_low       = (cfg_we && cfg_index == idq_pkg::CFG_START_LOW) ?
			$signed(cfg_data) : cfg_low_q;
		nb_count_raw = (cfg_we && cfg_index == idq_pkg::CFG_START_COUNT) ?
			cfg_data[CW-1:0] : cfg_count_q;
		nb_room      = {1'b0, 1'b1, {(DW-1){1'b0}}} - {nb_low[DW-1], nb_low};
		nb_count     = nb_count_raw;
		if (nb_count == '0) begin
			nb_count = CW'(1);
		end
		if (nb_count > CW'(idq_pkg::DEPTH)) begin
			nb_count = CW'(idq_pkg::DEPTH);
		end
		if ({{(DW+1-CW){1'b0}}, nb_count} > nb_room) begin
			nb_count = nb_room[CW-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_low_q   <= DW'(1);
			cfg_count_q <= CW'(1);
			cfg_fill_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				idq_pkg::CFG_START_LOW:   cfg_low_q   <= $signed(cfg_data);
				idq_pkg::CFG_START_COUNT: cfg_count_q <= cfg_data[CW-1:0];
				idq_pkg::CFG_FILL_VALUE:  cfg_fill_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= request;
		end
	end

	// stage 1: bounds check, slot selection and next state
	always_comb begin
		op_idx    = $signed(in_s1.index);
		high_cur  = low_q + $signed({{(DW-CW){1'b0}}, count_q}) - DW'(1);
		off_idx   = op_idx - low_q;
		last_off  = count_q - CW'(1);
		in_range  = (op_idx >= low_q) && (op_idx <= high_cur);
		is_full   = count_q >= CW'(idq_pkg::DEPTH);
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_slot   = ring_q;
		rd_slot   = ring_q;
		nxt_ring  = ring_q;
		nxt_low   = low_q;
		nxt_count = count_q;
		op_status = idq_pkg::ST_OK;
		case (in_s1.operation)
			idq_pkg::OP_FETCH, idq_pkg::OP_STORE: begin
				if (in_range) begin
					rd_slot = ring_q + off_idx[PW-1:0];
				end else begin
					rd_slot   = ring_q + last_off[PW-1:0];
					op_status = idq_pkg::ST_RANGE;
				end
				wr_slot = rd_slot;
				if (in_s1.operation == idq_pkg::OP_FETCH) begin
					rd_en = 1'b1;
				end else begin
					wr_en = 1'b1;
				end
			end
			idq_pkg::OP_PUSH_HIGH: begin
				if (is_full || high_cur == {1'b0, {(DW-1){1'b1}}}) begin
					op_status = idq_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_slot   = ring_q + count_q[PW-1:0];
					nxt_count = count_q + CW'(1);
				end
			end
			idq_pkg::OP_PUSH_LOW: begin
				if (is_full || low_q == {1'b1, {(DW-1){1'b0}}}) begin
					op_status = idq_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					nxt_ring  = ring_q - PW'(1);
					wr_slot   = nxt_ring;
					nxt_low   = low_q - DW'(1);
					nxt_count = count_q + CW'(1);
				end
			end
			idq_pkg::OP_POP_HIGH: begin
				if (count_q <= CW'(1)) begin
					op_status = idq_pkg::ST_LAST;
				end else begin
					rd_en     = 1'b1;
					rd_slot   = ring_q + last_off[PW-1:0];
					nxt_count = count_q - CW'(1);
				end
			end
			idq_pkg::OP_POP_LOW: begin
				if (count_q <= CW'(1)) begin
					op_status = idq_pkg::ST_LAST;
				end else begin
					rd_en     = 1'b1;
					rd_slot   = ring_q;
					nxt_ring  = ring_q + PW'(1);
					nxt_low   = low_q + DW'(1);
					nxt_count = count_q - CW'(1);
				end
			end
			default: ;
		endcase
		nxt_high = nxt_low + $signed({{(DW-CW){1'b0}}, nxt_count}) - DW'(1);
	end

	// deque state and filled marks, rebuilt by reset or a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q  <= '0;
			count_q <= CW'(1);
			low_q   <= DW'(1);
			mark_q  <= '1;
		end else if (rebuild) begin
			ring_q  <= '0;
			count_q <= nb_count;
			low_q   <= nb_low;
			mark_q  <= '1;
		end else if (v_s1) begin
			ring_q  <= nxt_ring;
			count_q <= nxt_count;
			low_q   <= nxt_low;
			if (wr_en) begin
				mark_q[wr_slot] <= 1'b0;
			end
		end
	end

	// element storage
	idq_ram #(
		.WIDTH (DW),
		.DEPTH (idq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (v_s1 && wr_en),
		.waddr (wr_slot),
		.wdata (in_s1.value),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	// stage 2: wait on the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rd_s2     <= rd_en;
			mark_s2   <= mark_q[rd_slot];
			low_s2    <= nxt_low;
			high_s2   <= nxt_high;
			count_s2  <= nxt_count;
			status_s2 <= op_status;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			result.data          <= !rd_s2 ? '0 : (mark_s2 ? cfg_fill_q : ram_rdata);
			result.low_index     <= low_s2;
			result.high_index    <= high_s2;
			result.element_count <= count_s2;
			result.status        <= status_s2;
		end
	end

	// every accepted word yields its result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result strobe missing after accepted word");

	// the element count stays within 1..DEPTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(idq_pkg::DEPTH))
		else $error("element count out of range");

	// the high bound never wraps past the top of the signed range
	a_high_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		!(low_q[DW-1] == 1'b0 && high_cur[DW-1] == 1'b1))
		else $error("high bound wrapped");

	// a refused push or pop leaves the count alone
	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !cfg_we && (op_status == idq_pkg::ST_FULL || op_status == idq_pkg::ST_LAST)
		|=> $stable(count_q))
		else $error("refused operation changed the count");

	// a written slot is no longer marked filled
	a_mark_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && wr_en && !cfg_we |=> !mark_q[$past(wr_slot)])
		else $error("filled mark not cleared on write");

endmodule
